/* hdl/assert_macros.svh */
// Assertion macros shared by the keypad decoder RTL.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hdl/rld_pkg.sv */
// Shared types, widths and codes for the resistor-ladder keypad decoder.
// No dependencies.
`default_nettype none

package rld_pkg;

  localparam int LEVEL_W   = 10;
  localparam int TIME_W    = 32;
  localparam int WINDOW_W  = 16;
  localparam int EVENT_W   = 4;
  localparam int BAND_W    = 2 * LEVEL_W;
  localparam int NUM_BANDS = 7;
  localparam int GROUP_W   = 3 * BAND_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = GROUP_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GROUND_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_WINDOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BANDS_SINGLE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BANDS_PAIRS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_TRIPLE      = 3'd4;

  localparam logic [EVENT_W-1:0] EV_NONE       = 4'd0;
  localparam logic [EVENT_W-1:0] EV_UNEXPECTED = 4'd8;

  typedef logic [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]                  ground_threshold;
    logic [WINDOW_W-1:0]                 search_window_ms;
    logic [NUM_BANDS-1:0][BAND_W-1:0]    bands;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/rld_cfg_regs.sv */
// Configuration register file of the keypad decoder.
// Depends on rld_pkg; presents all registers as one rld_pkg::cfg_t.
`default_nettype none

module rld_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wen,
  input  wire logic [rld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rld_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output rld_pkg::cfg_t                         cfg
);

  logic [rld_pkg::LEVEL_W-1:0]  ground_threshold;
  logic [rld_pkg::WINDOW_W-1:0] search_window_ms;
  logic [rld_pkg::GROUP_W-1:0]  bands_single;
  logic [rld_pkg::GROUP_W-1:0]  bands_pairs;
  logic [rld_pkg::BAND_W-1:0]   band_triple;

  always_ff @(posedge clk) begin
    if (rst) begin
      ground_threshold <= '0;
      search_window_ms <= '0;
      bands_single     <= '0;
      bands_pairs      <= '0;
      band_triple      <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        rld_pkg::REG_GROUND_THRESHOLD: ground_threshold <= cfg_wdata[rld_pkg::LEVEL_W-1:0];
        rld_pkg::REG_SEARCH_WINDOW:    search_window_ms <= cfg_wdata[rld_pkg::WINDOW_W-1:0];
        rld_pkg::REG_BANDS_SINGLE:     bands_single     <= cfg_wdata[rld_pkg::GROUP_W-1:0];
        rld_pkg::REG_BANDS_PAIRS:      bands_pairs      <= cfg_wdata[rld_pkg::GROUP_W-1:0];
        rld_pkg::REG_BAND_TRIPLE:      band_triple      <= cfg_wdata[rld_pkg::BAND_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ground_threshold = ground_threshold;
  assign cfg.search_window_ms = search_window_ms;
  assign cfg.bands = {band_triple, bands_pairs, bands_single};

endmodule

`default_nettype wire

/* hdl/rld_classify.sv */
// Band classifier: tests a level against seven bands, first match wins.
// Depends on rld_pkg for band layout and event codes.
`default_nettype none

module rld_classify (
  input  wire rld_pkg::cfg_t                  cfg,
  input  wire logic [rld_pkg::LEVEL_W-1:0]    level,
  output logic      [rld_pkg::EVENT_W-1:0]    button_event
);

  logic [rld_pkg::NUM_BANDS-1:0] hit;

  always_comb begin
    logic [rld_pkg::LEVEL_W-1:0] lo;
    logic [rld_pkg::LEVEL_W-1:0] span;
    logic [rld_pkg::LEVEL_W-1:0] diff;
    for (int k = 0; k < rld_pkg::NUM_BANDS; k++) begin
      lo     = cfg.bands[k][rld_pkg::LEVEL_W-1:0];
      span   = cfg.bands[k][rld_pkg::BAND_W-1:rld_pkg::LEVEL_W];
      diff   = level - lo;
      hit[k] = (lo <= level) && (diff <= span);
    end
  end

  // Lowest-numbered band takes priority.
  always_comb begin
    button_event = rld_pkg::EV_UNEXPECTED;
    for (int k = rld_pkg::NUM_BANDS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        button_event = rld_pkg::EVENT_W'(k + 1);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/resistor_ladder_button_decoder_core.sv */
// Top level of the resistor-ladder keypad decoder: stream ports, press tracking.
// Depends on rld_pkg, rld_cfg_regs, rld_classify and assert_macros.svh.
//
// Takes one poll (10-bit sample and millisecond time) per transaction and
// returns exactly one event transaction per poll, in order. Throughput is one
// poll per clock cycle while the result side accepts; a poll waits in the input
// register and passes the single press-tracking and band-compare stage into the
// result register. Backpressure on the result side stalls input acceptance.
// Configuration writes take effect on the following cycle and should only be
// made while no poll is in flight.
`default_nettype none
`include "assert_macros.svh"

module resistor_ladder_button_decoder_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wen,
  input  wire logic [rld_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rld_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [9:0] sample_level, [41:10] now_ms, [47:42] zero
  input  wire logic [rld_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [3:0] button_event, [13:4] peak_level, [15:14] zero
  output logic      [rld_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  rld_pkg::cfg_t cfg;

  logic                          in_valid;
  logic [rld_pkg::LEVEL_W-1:0]   in_level;
  logic [rld_pkg::TIME_W-1:0]    in_now;
  logic                          advance;

  logic                          out_valid;
  logic [rld_pkg::EVENT_W-1:0]   out_event;
  logic [rld_pkg::LEVEL_W-1:0]   out_peak;

  logic                          pressed_last_poll;
  logic [rld_pkg::TIME_W-1:0]    press_start_ms;
  logic                          classified_done;
  logic [rld_pkg::LEVEL_W-1:0]   peak_sample;

  logic                          pressed_last_poll_next;
  logic [rld_pkg::TIME_W-1:0]    press_start_ms_next;
  logic                          classified_done_next;
  logic [rld_pkg::LEVEL_W-1:0]   peak_sample_next;

  logic                          pressed;
  logic                          press_begin;
  logic                          done_eff;
  logic [rld_pkg::TIME_W-1:0]    window_end;
  logic                          track;
  logic [rld_pkg::LEVEL_W-1:0]   peak_eff;
  logic                          classify_now;
  logic [rld_pkg::EVENT_W-1:0]   class_event;

  rld_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rld_classify u_classify (
    .cfg          (cfg),
    .level        (peak_eff),
    .button_event (class_event)
  );

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_level <= s_axis_tdata[rld_pkg::LEVEL_W-1:0];
      in_now   <= s_axis_tdata[rld_pkg::LEVEL_W +: rld_pkg::TIME_W];
    end
  end

  always_comb begin
    pressed      = in_level > cfg.ground_threshold;
    press_begin  = pressed && !pressed_last_poll;
    press_start_ms_next = press_begin ? in_now : press_start_ms;
    done_eff     = press_begin ? 1'b0 : classified_done;
    window_end   = press_start_ms_next + {{(rld_pkg::TIME_W - rld_pkg::WINDOW_W){1'b0}},
                                          cfg.search_window_ms};
    track        = pressed && (in_now < window_end) && (in_level > peak_sample);
    peak_eff     = track ? in_level : peak_sample;
    classify_now = !done_eff && (in_now > window_end);

    pressed_last_poll_next = pressed;
    classified_done_next   = done_eff || classify_now;
    peak_sample_next       = classify_now ? '0 : peak_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_last_poll <= 1'b0;
      press_start_ms    <= '0;
      classified_done   <= 1'b1;
      peak_sample       <= '0;
    end else if (advance) begin
      pressed_last_poll <= pressed_last_poll_next;
      press_start_ms    <= press_start_ms_next;
      classified_done   <= classified_done_next;
      peak_sample       <= peak_sample_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event <= classify_now ? class_event : rld_pkg::EV_NONE;
      out_peak  <= classify_now ? peak_eff : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(rld_pkg::OUT_DATA_W - rld_pkg::EVENT_W - rld_pkg::LEVEL_W){1'b0}},
                          out_peak, out_event};

  `ASSERT_PROP(a_none_has_no_peak, clk, rst,
    (out_valid && out_event == rld_pkg::EV_NONE) |-> (out_peak == '0),
    "empty event carries a peak level")
  `ASSERT_PROP(a_classify_clears_peak, clk, rst,
    (advance && classify_now) |=> (peak_sample == '0 && classified_done),
    "peak not cleared after classification")
  `ASSERT_NEVER(a_event_range, clk, rst,
    out_valid && out_event > rld_pkg::EV_UNEXPECTED,
    "event code out of range")
  `ASSERT_PROP(a_done_blocks_event, clk, rst,
    (advance && classified_done && !press_begin) |=> (out_event == rld_pkg::EV_NONE),
    "event raised with nothing pending")

endmodule

`default_nettype wire
